[rtl/rle_pkg.sv]
// rle_pkg: shared types and constants for the run-length row decoder
// payload structs, config write struct, phase enum, status and register codes
// no dependencies
`default_nettype none

package rle_pkg;

	// result queue between the parser and the output stage
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// header byte fields
	localparam logic [7:0] HDR_REPEAT = 8'h80;
	localparam logic [7:0] HDR_COUNT  = 8'h7F;

	// bytes per pixel unit limits
	localparam logic [2:0] PB_MIN = 3'd1;
	localparam logic [2:0] PB_MAX = 3'd4;

	// configuration register indexes
	localparam logic CFG_PIXEL_BYTES = 1'b0;
	localparam logic CFG_ROW_UNITS   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_NORMAL    = 2'd0;
	localparam logic [1:0] ST_ZERO_END  = 2'd1;
	localparam logic [1:0] ST_EARLY_END = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       record_end;
	} code_in_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic [6:0]  run_count;
		logic        row_end;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

[rtl/rle_front.sv]
// rle_front: header/pixel parser of the run-length row decoder
// turns each code byte into at most one run result; depends on rle_pkg
`default_nettype none

module rle_front
	import rle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire cfg_wr_t  cfg_wr,
	input  wire logic     byte_take,
	input  wire code_in_t byte_in,
	output logic          res_push,
	output result_t       res_data
);

	logic [2:0]  pixel_bytes_q;
	logic [15:0] row_units_q;

	phase_t      phase_q, phase_n;
	logic [1:0]  idx_q, idx_n;
	logic [23:0] gather_q, gather_n;
	logic [6:0]  run_q, run_n;
	logic        rep_q, rep_n;
	logic [15:0] units_q, units_n;

	logic [7:0]  b;
	logic [31:0] val;
	logic        unit_done;
	logic [6:0]  cnt;
	logic [15:0] units_sub;
	logic        res_vld;
	result_t     res;

	assign b   = byte_in.code_byte;
	assign val = {8'd0, gather_q} | ({24'd0, b} << {idx_q, 3'b000});
	assign unit_done = ({1'b0, idx_q} + 3'd1) >= pixel_bytes_q;
	assign cnt = ({9'd0, run_q} < units_q) ? run_q : units_q[6:0];

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		gather_n  = gather_q;
		run_n     = run_q;
		rep_n     = rep_q;
		units_n   = units_q;
		res_vld   = 1'b0;
		res       = '0;
		units_sub = units_q;
		case (phase_q)
			PH_HEADER: begin
				if (units_q == 16'd0) begin
					phase_n = PH_SKIP;
				end else if ((b & HDR_REPEAT) != 8'd0) begin
					run_n    = b[6:0] & HDR_COUNT[6:0];
					rep_n    = 1'b1;
					idx_n    = 2'd0;
					gather_n = '0;
					phase_n  = PH_PIXEL;
				end else if (b == 8'd0) begin
					res_vld       = 1'b1;
					res.row_end   = 1'b1;
					res.status    = ST_ZERO_END;
					phase_n       = PH_SKIP;
				end else begin
					run_n    = b[6:0];
					rep_n    = 1'b0;
					idx_n    = 2'd0;
					gather_n = '0;
					phase_n  = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				if (unit_done) begin
					idx_n    = 2'd0;
					gather_n = '0;
					if (rep_q) begin
						units_sub = units_q - {9'd0, cnt};
						if (cnt != 7'd0) begin
							units_n       = units_sub;
							res_vld       = 1'b1;
							res.pixel     = val;
							res.run_count = cnt;
							res.row_end   = (units_sub == 16'd0);
							res.status    = ST_NORMAL;
						end
						run_n   = 7'd0;
						phase_n = (units_n == 16'd0) ? PH_SKIP : PH_HEADER;
					end else begin
						units_sub = units_q - 16'd1;
						if (units_q != 16'd0) begin
							units_n       = units_sub;
							res_vld       = 1'b1;
							res.pixel     = val;
							res.run_count = 7'd1;
							res.row_end   = (units_sub == 16'd0);
							res.status    = ST_NORMAL;
						end
						if (run_q != 7'd0) begin
							run_n = run_q - 7'd1;
						end
						if (units_n == 16'd0) begin
							phase_n = PH_SKIP;
						end else if (run_n == 7'd0) begin
							phase_n = PH_HEADER;
						end
					end
				end else begin
					gather_n = val[23:0];
					idx_n    = idx_q + 2'd1;
				end
			end
			default: begin
				// row full or ended: bytes are dropped until the record closes
			end
		endcase

		if (byte_in.record_end) begin
			// record closed before the row was complete
			if (phase_n != PH_SKIP && units_n != 16'd0) begin
				if (res_vld) begin
					res.row_end = 1'b1;
					res.status  = ST_EARLY_END;
				end else begin
					res_vld     = 1'b1;
					res         = '0;
					res.row_end = 1'b1;
					res.status  = ST_EARLY_END;
				end
			end
			phase_n  = PH_HEADER;
			idx_n    = 2'd0;
			gather_n = '0;
			run_n    = 7'd0;
			rep_n    = 1'b0;
			units_n  = row_units_q;
		end
	end

	assign res_push = byte_take && res_vld;
	assign res_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PB_MIN;
			row_units_q   <= 16'd1;
			phase_q       <= PH_HEADER;
			idx_q         <= 2'd0;
			gather_q      <= '0;
			run_q         <= 7'd0;
			rep_q         <= 1'b0;
			units_q       <= 16'd1;
		end else begin
			if (byte_take) begin
				phase_q  <= phase_n;
				idx_q    <= idx_n;
				gather_q <= gather_n;
				run_q    <= run_n;
				rep_q    <= rep_n;
			end
			// a row length write reloads the unit count of the current row
			if (cfg_we && cfg_wr.index == CFG_ROW_UNITS) begin
				units_q <= cfg_wr.data;
			end else if (byte_take) begin
				units_q <= units_n;
			end
			if (cfg_we) begin
				case (cfg_wr.index)
					CFG_PIXEL_BYTES: begin
						if (cfg_wr.data[2:0] < PB_MIN) begin
							pixel_bytes_q <= PB_MIN;
						end else if (cfg_wr.data[2:0] > PB_MAX) begin
							pixel_bytes_q <= PB_MAX;
						end else begin
							pixel_bytes_q <= cfg_wr.data[2:0];
						end
					end
					CFG_ROW_UNITS: begin
						row_units_q <= cfg_wr.data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_marker_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.status != ST_NORMAL |-> res_data.row_end)
		else $error("end status without row_end");

	a_zero_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.status == ST_ZERO_END |->
			res_data.run_count == 7'd0 && res_data.pixel == 32'd0)
		else $error("zero end marker carries data");

	a_pb_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_bytes_q >= PB_MIN && pixel_bytes_q <= PB_MAX)
		else $error("pixel_bytes out of range");

endmodule

`default_nettype wire

[rtl/rle_queue.sv]
// rle_queue: small result queue between parser and output stage
// depends on rle_pkg for the result struct and depth
`default_nettype none

module rle_queue
	import rle_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t wdata,
	input  wire logic    pop,
	output result_t      rdata,
	output logic         empty,
	output logic         full
);

	result_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QAW-1:0])
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/rle_back.sv]
// rle_back: output register stage of the run-length row decoder
// drains the result queue onto the valid/ready result channel; depends on rle_pkg
`default_nettype none

module rle_back
	import rle_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_empty,
	input  wire result_t q_data,
	output logic         q_pop,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    valid_q;
	result_t data_q;

	// refill whenever the register is empty or being drained this cycle
	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/rle_row_decoder.sv]
// rle_row_decoder: top level of the packbits-style run-length row decoder
// ties parser, result queue and output stage together; depends on rle_pkg
//
// usage
//  - in channel (in_valid/in_ready/in_data): one code byte per transfer, with
//    record_end set on the last byte of a row record
//  - out channel (out_valid/out_ready/out_data): zero or one result per byte,
//    a pixel unit with its run count, row_end and status
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets bytes
//    per pixel (clamped to 1..4), index 1 sets pixel units per row and
//    restarts the unit count of the row; cfg_ready is always high; the user must
//    make writes only while the decoder is idle, which the block does not enforce
//  - throughput: one byte per cycle while the result queue is not full; each
//    byte transfer updates the phase/count registers
//  - result path: a result is written into the queue at its byte transfer and
//    then moved into the output register that drives out_valid
//  - receiver stall: results collect in a four-entry queue; in_ready drops
//    only once that queue is full
//  - reset: bytes per pixel 1, row length 1, parser waits for a header,
//    queue and output register empty
`default_nettype none

module rle_row_decoder
	import rle_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire code_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output result_t          out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic    byte_take;
	logic    res_push;
	result_t res_data;
	result_t q_data;
	logic    q_empty;
	logic    q_full;
	logic    q_pop;
	cfg_wr_t cfg_wr;

	// a byte may always produce a result, so only take it with a free slot
	assign in_ready  = !q_full;
	assign byte_take = in_valid && in_ready;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	rle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wr    (cfg_wr),
		.byte_take (byte_take),
		.byte_in   (in_data),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	rle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty),
		.full   (q_full)
	);

	rle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[tb/sv/rle_row_decoder_tb.sv]
// rle_row_decoder_tb: self-checking testbench for the run-length row decoder
// queued byte driver, stalling result receiver and an in-order decoder predictor
// depends on rle_pkg and rle_row_decoder
`default_nettype none

module rle_row_decoder_tb;
	import rle_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 100;
	localparam int RANDOM_ITEMS = 550;
	localparam int MAX_REPORTS  = 10;

	// one queued code byte with the idle gap that follows its transfer
	typedef struct {
		code_in_t data;
		int       gap;
		bit       drain;
	} feed_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	code_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	result_t     out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// transfer flags from the last rising edge, read at the falling edge
	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic cfg_took = 1'b0;

	feed_item_t  code_feed[$];
	result_t     expected_runs[$];
	logic [7:0]  rec_bytes[$];

	int feed_mode = 0;
	int rx_mode = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int rx_wait = 0;
	int gap_left = 0;
	int cur_gap = 0;
	int bad_results = 0;
	int cycle_count = 0;

	// predictor state: configuration and parser
	logic [2:0]  unit_size;
	logic [15:0] row_len;
	phase_t      dec_phase;
	logic [1:0]  dec_byte_pos;
	logic [23:0] dec_partial;
	logic [6:0]  dec_run;
	logic        dec_is_repeat;
	logic [15:0] dec_units_todo;

	rle_row_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// idle cycles for one item: 0 never idles, 1 full range, else mostly busy
	function automatic int draw_wait(input int mode);
		if (mode == 0) return 0;
		if (mode == 1) return $urandom_range(0, 19);
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19) : 0;
	endfunction

	function automatic void restart_row();
		dec_phase = PH_HEADER;
		dec_byte_pos = '0;
		dec_partial = '0;
		dec_run = '0;
		dec_is_repeat = 1'b0;
		dec_units_todo = row_len;
	endfunction

	// advance the parser by one code byte and queue the run it yields, if any
	task automatic decode_code_byte(input code_in_t c);
		result_t     run;
		bit          made;
		logic [31:0] unit_val;
		logic [15:0] take;
		made = 1'b0;
		run = '0;
		case (dec_phase)
			PH_HEADER: begin
				if (dec_units_todo == 16'd0) begin
					// row already complete, rest of the record is dropped
					dec_phase = PH_SKIP;
				end else if ((c.code_byte & HDR_REPEAT) != 8'd0) begin
					dec_run = 7'(c.code_byte & HDR_COUNT);
					dec_is_repeat = 1'b1;
					dec_byte_pos = '0;
					dec_partial = '0;
					dec_phase = PH_PIXEL;
				end else if (c.code_byte == 8'd0) begin
					// zero header closes the row with a marker
					run.row_end = 1'b1;
					run.status = ST_ZERO_END;
					made = 1'b1;
					dec_phase = PH_SKIP;
				end else begin
					dec_run = c.code_byte[6:0];
					dec_is_repeat = 1'b0;
					dec_byte_pos = '0;
					dec_partial = '0;
					dec_phase = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				unit_val = {8'd0, dec_partial} | (32'(c.code_byte) << (8 * dec_byte_pos));
				if (int'(dec_byte_pos) + 1 >= int'(unit_size)) begin
					dec_byte_pos = '0;
					dec_partial = '0;
					if (dec_is_repeat) begin
						// repeat run clipped to what the row still misses
						take = (16'(dec_run) < dec_units_todo) ? 16'(dec_run) : dec_units_todo;
						if (take != 16'd0) begin
							dec_units_todo = dec_units_todo - take;
							run.pixel = unit_val;
							run.run_count = take[6:0];
							run.row_end = (dec_units_todo == 16'd0);
							run.status = ST_NORMAL;
							made = 1'b1;
						end
						dec_run = '0;
						if (dec_units_todo == 16'd0) dec_phase = PH_SKIP;
						else dec_phase = PH_HEADER;
					end else begin
						// literal units past the row end are eaten silently
						if (dec_units_todo != 16'd0) begin
							dec_units_todo = dec_units_todo - 16'd1;
							run.pixel = unit_val;
							run.run_count = 7'd1;
							run.row_end = (dec_units_todo == 16'd0);
							run.status = ST_NORMAL;
							made = 1'b1;
						end
						if (dec_run != 7'd0) dec_run = dec_run - 7'd1;
						if (dec_units_todo == 16'd0) dec_phase = PH_SKIP;
						else if (dec_run == 7'd0) dec_phase = PH_HEADER;
					end
				end else begin
					dec_partial = unit_val[23:0];
					dec_byte_pos = dec_byte_pos + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (c.record_end) begin
			// record closed before the row filled up
			if (dec_phase != PH_SKIP && dec_units_todo != 16'd0) begin
				if (!made) begin
					run = '0;
					made = 1'b1;
				end
				run.row_end = 1'b1;
				run.status = ST_EARLY_END;
			end
			restart_row();
		end
		if (made) expected_runs.push_back(run);
	endtask

	// rising edge: note transfers, track config, predict and check results
	always @(posedge clk) begin
		result_t want;
		in_took <= arst_n && in_valid && in_ready;
		out_took <= arst_n && out_valid && out_ready;
		cfg_took <= arst_n && cfg_valid && cfg_ready;
		if (!arst_n) begin
			unit_size = PB_MIN;
			row_len = 16'd1;
			restart_row();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PIXEL_BYTES) begin
					// out-of-range unit sizes are clamped
					if (cfg_data[2:0] < PB_MIN) unit_size = PB_MIN;
					else if (cfg_data[2:0] > PB_MAX) unit_size = PB_MAX;
					else unit_size = cfg_data[2:0];
				end else begin
					// new row length restarts the unit count of the row
					row_len = cfg_data;
					dec_units_todo = cfg_data;
				end
			end
			if (in_valid && in_ready) decode_code_byte(in_data);
			if (out_valid && out_ready) begin
				if (expected_runs.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("unexpected result: pixel %h run_count %0d row_end %0b status %0d",
							out_data.pixel, out_data.run_count, out_data.row_end,
							out_data.status);
				end else begin
					want = expected_runs.pop_front();
					if (out_data.pixel !== want.pixel || out_data.run_count !== want.run_count ||
							out_data.row_end !== want.row_end || out_data.status !== want.status) begin
						bad_results++;
						if (bad_results <= MAX_REPORTS)
							$display("mismatch: expected %h/%0d/%0b/%0d got %h/%0d/%0b/%0d",
								want.pixel, want.run_count, want.row_end, want.status,
								out_data.pixel, out_data.run_count, out_data.row_end,
								out_data.status);
					end
				end
			end
		end
	end

	// byte driver: holds valid until transfer, then idles for the item's gap
	always @(negedge clk) begin
		feed_item_t head;
		logic       v;
		code_in_t   d;
		v = in_valid;
		d = in_data;
		if (!in_valid || in_took) begin
			v = 1'b0;
			if (in_valid) gap_left = cur_gap;
			if (gap_left != 0) begin
				gap_left--;
			end else if (code_feed.size() != 0 &&
					!(code_feed[0].drain && expected_runs.size() != 0)) begin
				// a drain item waits until every pending result came out
				head = code_feed.pop_front();
				d = head.data;
				cur_gap = head.gap;
				v = 1'b1;
			end
		end
		in_valid <= v;
		in_data <= d;
	end

	// result receiver: random stall after each transfer, long hold on request
	always @(negedge clk) begin
		logic rdy;
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			if (out_took) rx_wait = draw_wait(rx_mode);
			if (rx_wait != 0) begin
				rx_wait--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
		end
		out_ready <= rdy;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic feed_byte(input logic [7:0] b, input logic rec_end, input bit drain);
		feed_item_t item;
		item.data = {b, rec_end};
		item.gap = draw_wait(feed_mode);
		item.drain = drain;
		code_feed.push_back(item);
	endtask

	// register write over the config channel, only while the decoder is idle
	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	// everything sent and answered, plus slack for bytes that yield nothing
	task automatic wait_until_idle();
		do @(negedge clk); while (code_feed.size() != 0 || in_valid || expected_runs.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// mostly well-formed row record: repeat and literal runs until the row fills or a zero header ends it
	task automatic build_record(input int units, input int upb);
		int left;
		int kind;
		int cnt;
		int k;
		rec_bytes.delete();
		left = units;
		while (left > 0 && rec_bytes.size() < 48) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				rec_bytes.push_back(8'h00);
				left = 0;
			end else if (kind < 9) begin
				cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
				rec_bytes.push_back(HDR_REPEAT | 8'(cnt));
				repeat (upb) rec_bytes.push_back(8'($urandom));
				left -= (cnt < left) ? cnt : left;
			end else begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 5);
				rec_bytes.push_back(8'(cnt));
				// very long literals get cut, which ends the record early
				for (k = 0; k < cnt * upb && rec_bytes.size() < 64; k++)
					rec_bytes.push_back(8'($urandom));
				left -= (cnt < left) ? cnt : left;
			end
		end
		// trailing bytes after a full row are ignored by the decoder
		repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom));
	endtask

	initial begin
		int  k;
		int  n;
		int  pick;
		int  raw;
		int  nrec;
		int  style;
		int  gen_upb;
		int  gen_row;
		int  random_items;
		bit  open_end;

		random_items = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: one-byte units, eight-unit rows
		write_reg(CFG_PIXEL_BYTES, 16'd1);
		write_reg(CFG_ROW_UNITS, 16'd8);
		feed_mode = 2;
		rx_mode = 2;
		feed_byte(8'h02, 1'b0, 1'b0);  // literal of two, extreme pixel values
		feed_byte(8'h00, 1'b0, 1'b0);
		feed_byte(8'hFF, 1'b0, 1'b0);
		feed_byte(8'h80, 1'b0, 1'b0);  // repeat with count zero, no result
		feed_byte(8'hAA, 1'b0, 1'b0);
		feed_byte(8'hFF, 1'b0, 1'b0);  // longest repeat, clipped to the row
		feed_byte(8'h5A, 1'b0, 1'b0);
		feed_byte(8'h12, 1'b0, 1'b0);  // bytes after a full row
		feed_byte(8'h34, 1'b1, 1'b0);
		feed_byte(8'h00, 1'b0, 1'b0);  // zero header ends the row
		feed_byte(8'h77, 1'b1, 1'b0);
		feed_byte(8'h03, 1'b0, 1'b0);  // record ends on a pixel byte
		feed_byte(8'h11, 1'b1, 1'b0);
		feed_byte(8'h85, 1'b1, 1'b0);  // record ends on a header

		// directed: unit size written too large, longest row
		wait_until_idle();
		write_reg(CFG_PIXEL_BYTES, 16'd7);
		write_reg(CFG_ROW_UNITS, 16'hFFFF);
		feed_byte(8'h81, 1'b0, 1'b0);
		repeat (4) feed_byte(8'hFF, 1'b0, 1'b0);
		feed_byte(8'h7F, 1'b0, 1'b0);
		feed_byte(8'h01, 1'b0, 1'b0);
		feed_byte(8'h02, 1'b0, 1'b0);
		feed_byte(8'h03, 1'b0, 1'b0);
		feed_byte(8'h04, 1'b1, 1'b0);

		// directed: unit size zero, empty rows swallow everything
		wait_until_idle();
		write_reg(CFG_PIXEL_BYTES, 16'd0);
		write_reg(CFG_ROW_UNITS, 16'd0);
		feed_byte(8'h81, 1'b0, 1'b0);
		feed_byte(8'h55, 1'b0, 1'b0);
		feed_byte(8'h00, 1'b1, 1'b0);

		// back pressure: receiver holds off while a long literal streams in
		wait_until_idle();
		write_reg(CFG_PIXEL_BYTES, 16'd1);
		write_reg(CFG_ROW_UNITS, 16'd40);
		feed_mode = 0;
		rx_mode = 0;
		@(posedge clk);
		hold_asked++;
		feed_byte(8'd40, 1'b0, 1'b0);
		for (k = 0; k < 40; k++) feed_byte(8'($urandom), k == 39, 1'b0);
		// next row only starts once the receiver drained every result
		feed_byte(8'h81, 1'b0, 1'b1);
		feed_byte(8'h3C, 1'b1, 1'b0);
		random_items += 43;
		gen_upb = 1;
		gen_row = 40;

		// random phases, each with its own settings and idle behavior
		while (random_items < RANDOM_ITEMS) begin
			wait_until_idle();
			pick = $urandom_range(0, 7);
			if (pick < 5) begin
				raw = (pick == 0) ? 0 : ((pick == 1) ? $urandom_range(5, 7) : $urandom_range(1, 4));
				write_reg(CFG_PIXEL_BYTES, 16'(raw));
				gen_upb = (raw == 0) ? 1 : ((raw > 4) ? 4 : raw);
			end
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				case (pick)
					0: gen_row = 65535;
					1: gen_row = 1;
					2, 3: gen_row = $urandom_range(1, 200);
					default: gen_row = $urandom_range(2, 24);
				endcase
				write_reg(CFG_ROW_UNITS, 16'(gen_row));
			end
			feed_mode = $urandom_range(0, 2);
			rx_mode = $urandom_range(0, 2);
			nrec = $urandom_range(2, 6);
			for (k = 0; k < nrec; k++) begin
				style = $urandom_range(0, 9);
				if (style < 8) begin
					build_record(gen_row, gen_upb);
					// some records are cut short anywhere
					if (style >= 6) begin
						n = $urandom_range(1, rec_bytes.size());
						while (rec_bytes.size() > n) void'(rec_bytes.pop_back());
					end
					// the last record may stay open so the next write lands mid-row
					open_end = (k == nrec - 1) && ($urandom_range(0, 3) == 0);
					for (n = 0; n < rec_bytes.size(); n++)
						feed_byte(rec_bytes[n], !open_end && n == rec_bytes.size() - 1,
							$urandom_range(0, 39) == 0);
					random_items += rec_bytes.size();
				end else begin
					// noise with random record ends
					n = $urandom_range(1, 12);
					repeat (n) feed_byte(8'($urandom), $urandom_range(0, 5) == 0, 1'b0);
					random_items += n;
				end
			end
		end

		wait_until_idle();
		repeat (10) @(negedge clk);
		if (expected_runs.size() != 0)
			$display("%0d expected results never arrived", expected_runs.size());
		if (bad_results == 0 && expected_runs.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/rle_pkg.sv
rtl/rle_front.sv
rtl/rle_queue.sv
rtl/rle_back.sv
rtl/rle_row_decoder.sv
tb/sv/rle_row_decoder_tb.sv
